### rtl/assert_macros.svh
// Assertion helpers used by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// check that a condition implies a property on the next edge
`define ASSERT_NEXT(lbl, clk, rst, cond, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("assertion failed");
// check that a condition implies a property on the same edge
`define ASSERT_NOW(lbl, clk, rst, cond, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("assertion failed");
`endif

### rtl/tpt_pkg.sv
// ---------------------------------------------------------------------------
// tpt_pkg
// Operation and status codes of the tool pocket table.
// ---------------------------------------------------------------------------
package tpt_pkg;
  localparam logic [3:0] OP_REGISTER = 4'd0;
  localparam logic [3:0] OP_ADD      = 4'd1;
  localparam logic [3:0] OP_REMOVE   = 4'd2;
  localparam logic [3:0] OP_DELETE   = 4'd3;
  localparam logic [3:0] OP_CHANGED  = 4'd4;
  localparam logic [3:0] OP_FIND     = 4'd5;
  localparam logic [3:0] OP_FINDPKT  = 4'd6;
  localparam logic [3:0] OP_SELECT   = 4'd7;
  localparam logic [3:0] OP_SELNEXT  = 4'd8;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_ALREADY = 3'd1;
  localparam logic [2:0] ST_NOTLOAD = 3'd2;
  localparam logic [2:0] ST_INPKT   = 3'd3;
  localparam logic [2:0] ST_NOPKT   = 3'd4;
  localparam logic [2:0] ST_NOTFND  = 3'd5;
  localparam logic [2:0] ST_FULL    = 3'd6;

  localparam logic [0:0] CFG_LIMIT = 1'd0;
  localparam logic [0:0] CFG_READY = 1'd1;
endpackage

### rtl/tpt_ram.sv
// ---------------------------------------------------------------------------
// tpt_ram
// Generic single write port RAM with registered read.
// ---------------------------------------------------------------------------
module tpt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

### rtl/tool_pocket_table.sv
// ---------------------------------------------------------------------------
// tool_pocket_table
// Tool and carousel pocket table for a random tool changer.
// ---------------------------------------------------------------------------
// One request is taken while busy is low and answered by a one-cycle done
// strobe; the receiver cannot stall it. Requests that need no search (select,
// select next with no pocket limit, unused codes, table edits on an unloaded
// table) go from idle straight to the done state. Every other request scans
// the entry memory one entry a cycle through a single read port. Find by
// pocket makes one table pass and goes to done; other single-pass requests
// pass through a decide state first. A tool change makes a second pass when
// the outgoing tool goes back to the carousel. Each pocket tried by the
// free-pocket search adds a further table pass, and at most TABLE_ENTRIES+1
// pockets can be tried. The shared memory read port paces every pass.
// Configuration writes are taken only while busy is low. No clearing pass is
// needed.
`include "assert_macros.svh"

module tool_pocket_table #(
  parameter int TABLE_ENTRIES = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [3:0]  op,
  input  logic [15:0] tool_number,
  input  logic [7:0]  pocket_query,
  input  logic        name_given,
  input  logic [15:0] spindle_tool,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [0:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  output logic        done,
  output logic [2:0]  status,
  output logic        found,
  output logic [15:0] tool_out,
  output logic [7:0]  pocket_out,
  output logic [7:0]  arriving_pocket
);
  localparam int AW = $clog2(TABLE_ENTRIES);
  localparam int CW = $clog2(TABLE_ENTRIES + 1);

  // sequencer states
  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_SCAN   = 4'd1;  // search tool, count carousel
  localparam logic [3:0] S_DECIDE = 4'd2;
  localparam logic [3:0] S_PSCAN  = 4'd3;  // test one candidate pocket
  localparam logic [3:0] S_PNEXT  = 4'd4;
  localparam logic [3:0] S_WRITE  = 4'd5;
  localparam logic [3:0] S_QSCAN  = 4'd6;  // find by pocket
  localparam logic [3:0] S_DONE   = 4'd7;
  localparam logic [3:0] S_CH2    = 4'd8;  // change: outgoing tool return

  logic [3:0]  state;
  logic [AW:0] idx;            // scan position, one beyond last ends pass
  logic [3:0]  cop;
  logic [15:0] ctool;
  logic [7:0]  cpq;
  logic        cname;
  logic [15:0] cspt;
  logic [7:0]  pocket_limit;
  logic        table_ready;
  logic [TABLE_ENTRIES-1:0] valid;
  logic [CW-1:0] entry_count;
  logic [15:0] spindle_current;
  logic [7:0]  fetched_pocket;

  // scan results
  logic          hit;
  logic [AW-1:0] hit_slot;
  logic [7:0]  hit_pocket;
  logic [15:0] hit_tool;
  logic        free_ok;
  logic [AW-1:0] free_slot;
  logic [CW-1:0] ncar;
  logic [7:0]  cand;
  logic        taken;
  logic [8:0]  lim;
  // change bookkeeping
  logic        ch_phase;       // 0 incoming, 1 outgoing return
  logic        ch_found;
  logic [7:0]  ch_inp;
  logic [15:0] ch_prev;

  logic [2:0]  r_status;
  logic        r_found;
  logic [15:0] r_tool;
  logic [7:0]  r_pocket;
  logic [7:0]  r_inp;

  // memory ports
  logic          we;
  logic [AW-1:0] waddr;
  logic [15:0]   wtool;
  logic [7:0]    wpocket;
  logic [AW-1:0] raddr;
  logic [15:0]   rtool;
  logic [7:0]    rpocket;
  logic [AW:0]   pidx;         // one plus the address of data now on the read port

  assign raddr = idx[AW-1:0];
  tpt_ram #(.WIDTH(16), .DEPTH(TABLE_ENTRIES)) u_tool (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wtool), .raddr(raddr), .rdata(rtool));
  tpt_ram #(.WIDTH(8), .DEPTH(TABLE_ENTRIES)) u_pocket (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wpocket), .raddr(raddr), .rdata(rpocket));

  assign busy = (state != S_IDLE);
  assign cfg_ready = !busy;

  logic pvalid;
  logic scan_end;
  assign pvalid   = (pidx != 0) && (pidx <= (AW+1)'(TABLE_ENTRIES))
                    && valid[pidx[AW-1:0] - AW'(1)];
  assign scan_end = (idx == (AW+1)'(TABLE_ENTRIES));
  logic [AW-1:0] cur;
  assign cur = pidx[AW-1:0] - AW'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      valid <= '0;
      entry_count <= '0;
      spindle_current <= '0;
      fetched_pocket <= '0;
      pocket_limit <= '0;
      table_ready <= 1'b0;
      done <= 1'b0;
      we <= 1'b0;
    end else begin
      done <= 1'b0;
      we <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == tpt_pkg::CFG_LIMIT) pocket_limit <= cfg_data;
        else table_ready <= cfg_data[0];
      end
      unique case (state)
        S_IDLE: begin
          if (start) begin
            cop <= op; ctool <= tool_number; cpq <= pocket_query;
            cname <= name_given; cspt <= spindle_tool;
            r_status <= tpt_pkg::ST_OK; r_found <= 1'b0; r_tool <= '0;
            r_pocket <= '0; r_inp <= '0; ch_phase <= 1'b0;
            ch_prev <= spindle_current;
            idx <= '0; pidx <= '0;
            hit <= 1'b0; free_ok <= 1'b0; ncar <= '0;
            if (op == tpt_pkg::OP_FINDPKT) state <= S_QSCAN;
            else if (op == tpt_pkg::OP_SELECT) begin
              spindle_current <= tool_number;
              r_pocket <= fetched_pocket;
              state <= S_DONE;
            end else if (op == tpt_pkg::OP_SELNEXT && pocket_limit == 0) state <= S_DONE;
            else if (op > tpt_pkg::OP_SELNEXT) state <= S_DONE;
            else if (!table_ready && op <= tpt_pkg::OP_DELETE) begin
              r_status <= tpt_pkg::ST_NOTLOAD;
              state <= S_DONE;
            end else state <= S_SCAN;
          end
        end
        S_SCAN, S_QSCAN: begin
          // one entry per cycle; read data arrives in the cycle after its address
          if (pvalid) begin
            if (state == S_SCAN && !hit && rtool == ctool) begin
              hit <= 1'b1; hit_slot <= cur; hit_pocket <= rpocket;
            end
            if (state == S_QSCAN && !hit && cpq != 0 && rpocket == cpq) begin
              hit <= 1'b1; hit_tool <= rtool;
            end
            if (rpocket != 0) ncar <= ncar + CW'(1);
          end
          if (pidx != 0 && pidx <= (AW+1)'(TABLE_ENTRIES) && !valid[cur] && !free_ok) begin
            free_ok <= 1'b1; free_slot <= cur;
          end
          if (pidx == (AW+1)'(TABLE_ENTRIES)) state <= (state == S_SCAN) ? S_DECIDE : S_DONE;
          if (state == S_QSCAN && pidx == (AW+1)'(TABLE_ENTRIES)) begin
            if (hit || (pvalid && cpq != 0 && rpocket == cpq && !hit)) begin
              r_found <= 1'b1; r_pocket <= cpq;
              r_tool <= hit ? hit_tool : rtool;
            end else r_status <= tpt_pkg::ST_NOTFND;
          end
          if (!scan_end) idx <= idx + (AW+1)'(1);
          pidx <= idx + (AW+1)'(1);
        end
        S_DECIDE: begin
          state <= S_DONE;
          lim <= (pocket_limit != 0) ? {1'b0, pocket_limit}
               : ((9'(entry_count) + 9'd1 > 9'd255) ? 9'd255 : 9'(entry_count) + 9'd1);
          cand <= 8'd1;
          unique case (cop)
            tpt_pkg::OP_REGISTER: begin
              if (hit) begin
                r_found <= 1'b1; r_pocket <= hit_pocket;
                r_status <= cname ? tpt_pkg::ST_OK : tpt_pkg::ST_ALREADY;
              end else if (!free_ok) r_status <= tpt_pkg::ST_FULL;
              else begin
                we <= 1'b1; waddr <= free_slot; wtool <= ctool; wpocket <= '0;
                valid[free_slot] <= 1'b1; entry_count <= entry_count + CW'(1);
              end
            end
            tpt_pkg::OP_ADD: begin
              if (hit && hit_pocket != 0) begin
                r_status <= tpt_pkg::ST_INPKT; r_pocket <= hit_pocket;
              end else if (pocket_limit != 0 && 9'(ncar) >= {1'b0, pocket_limit})
                r_status <= tpt_pkg::ST_NOPKT;
              else begin
                idx <= '0; pidx <= '0; taken <= 1'b0; state <= S_PSCAN;
              end
            end
            tpt_pkg::OP_REMOVE: begin
              if (!hit || hit_pocket == 0) r_status <= tpt_pkg::ST_NOTFND;
              else begin
                r_pocket <= hit_pocket;
                we <= 1'b1; waddr <= hit_slot; wtool <= ctool; wpocket <= '0;
              end
            end
            tpt_pkg::OP_DELETE: begin
              if (!hit) r_status <= tpt_pkg::ST_NOTFND;
              else if (hit_pocket != 0) begin
                r_status <= tpt_pkg::ST_INPKT; r_pocket <= hit_pocket;
              end else begin
                valid[hit_slot] <= 1'b0;
                if (entry_count != 0) entry_count <= entry_count - CW'(1);
              end
            end
            tpt_pkg::OP_CHANGED: begin
              if (!ch_phase) begin
                ch_found <= hit;
                ch_inp <= '0;
                if (!table_ready) r_status <= tpt_pkg::ST_NOTLOAD;
                else if (!hit && !free_ok) r_status <= tpt_pkg::ST_FULL;
                else if (!hit) begin
                  we <= 1'b1; waddr <= free_slot; wtool <= ctool; wpocket <= '0;
                  valid[free_slot] <= 1'b1; entry_count <= entry_count + CW'(1);
                end
                // capture the incoming pocket; free it only on a loaded table
                if (pocket_limit != 0 && hit && hit_pocket != 0) begin
                  ch_inp <= hit_pocket;
                  if (table_ready) begin
                    we <= 1'b1; waddr <= hit_slot; wtool <= ctool; wpocket <= '0;
                  end
                end
                state <= S_CH2;
              end else begin
                // outgoing tool add, same rules as add
                if (!table_ready) r_status <= tpt_pkg::ST_NOTLOAD;
                else if (hit && hit_pocket != 0) begin
                  if (r_status == tpt_pkg::ST_OK) r_status <= tpt_pkg::ST_INPKT;
                end else if (pocket_limit != 0 && 9'(ncar) >= {1'b0, pocket_limit}) begin
                  if (r_status == tpt_pkg::ST_OK) r_status <= tpt_pkg::ST_NOPKT;
                end else begin
                  idx <= '0; pidx <= '0; taken <= 1'b0; state <= S_PSCAN;
                end
              end
            end
            tpt_pkg::OP_FIND: begin
              if (hit) begin r_found <= 1'b1; r_pocket <= hit_pocket; end
              else r_status <= tpt_pkg::ST_NOTFND;
            end
            tpt_pkg::OP_SELNEXT: begin
              r_found <= hit;
              if (hit && hit_pocket != 0) r_inp <= hit_pocket;
              r_tool <= cspt; r_pocket <= fetched_pocket;
            end
            default: ;
          endcase
        end
        S_CH2: begin
          spindle_current <= ctool;
          r_found <= ch_found; r_tool <= ch_prev;
          if (pocket_limit == 0) begin
            r_pocket <= fetched_pocket;
            state <= S_DONE;
          end else begin
            fetched_pocket <= ch_inp;
            r_pocket <= ch_inp; r_inp <= ch_inp;
            if (fetched_pocket == 0) state <= S_DONE;
            else begin
              // rescan for the outgoing tool
              ch_phase <= 1'b1; ctool <= ch_prev;
              idx <= '0; pidx <= '0; hit <= 1'b0; free_ok <= 1'b0; ncar <= '0;
              state <= S_SCAN;
            end
          end
        end
        S_PSCAN: begin
          // is pocket cand taken by any valid entry
          if (pvalid && rpocket == cand) taken <= 1'b1;
          if (!scan_end) idx <= idx + (AW+1)'(1);
          pidx <= idx + (AW+1)'(1);
          if (pidx == (AW+1)'(TABLE_ENTRIES)) state <= S_PNEXT;
        end
        S_PNEXT: begin
          if (!taken) begin
            state <= S_WRITE;
          end else if ({1'b0, cand} >= lim) begin
            if (cop == tpt_pkg::OP_ADD || r_status == tpt_pkg::ST_OK)
              r_status <= tpt_pkg::ST_NOPKT;
            state <= S_WRITE;
            cand <= '0;
          end else begin
            cand <= cand + 8'd1; taken <= 1'b0;
            idx <= '0; pidx <= '0; state <= S_PSCAN;
          end
        end
        S_WRITE: begin
          state <= S_DONE;
          if (cand != 0) begin
            if (hit) begin
              we <= 1'b1; waddr <= hit_slot; wtool <= ctool; wpocket <= cand;
              if (cop == tpt_pkg::OP_ADD) r_pocket <= cand;
            end else if (!free_ok) begin
              if (cop == tpt_pkg::OP_ADD || r_status == tpt_pkg::ST_OK)
                r_status <= tpt_pkg::ST_FULL;
            end else begin
              we <= 1'b1; waddr <= free_slot; wtool <= ctool; wpocket <= cand;
              valid[free_slot] <= 1'b1; entry_count <= entry_count + CW'(1);
              if (cop == tpt_pkg::OP_ADD) r_pocket <= cand;
            end
          end
        end
        S_DONE: begin
          done <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign status = r_status;
  assign found = r_found;
  assign tool_out = r_tool;
  assign pocket_out = r_pocket;
  assign arriving_pocket = r_inp;

  `ASSERT_NEXT(a_done_single, clk, rst, done, !done)
  `ASSERT_NOW(a_no_start_busy, clk, rst, done, !busy)
  `ASSERT_NEXT(a_take, clk, rst, start && !busy, busy)
  `ASSERT_NOW(a_count, clk, rst, 1'b1, entry_count == CW'($countones(valid)))
endmodule

### sim/tb_tool_pocket_table.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_tool_pocket_table
// Self-checking bench for the tool pocket table. A directed list of requests
// covers reset behaviour, every operation and the not-loaded, already,
// in-pocket and not-found codes. Random requests on a small pool of tool
// numbers then run under several pocket limits, table loaded and unloaded.
// Answers are checked against typed values or a bench pocket model.
// ---------------------------------------------------------------------------
module tb_tool_pocket_table;

  localparam int          ENTRIES   = 64;
  localparam logic [3:0]  OP_UNUSED = 4'd15;
  localparam longint      MAX_CYC   = 30_000_000;

  typedef struct packed {
    logic [2:0]  st;
    logic        fnd;
    logic [15:0] tool;
    logic [7:0]  pkt;
    logic [7:0]  inp;
  } answer_t;

  typedef struct {
    bit          is_cfg;
    logic [0:0]  idx;
    logic [7:0]  val;
    logic [3:0]  op;
    logic [15:0] tool;
    logic [7:0]  pq;
    logic        nm;
    logic [15:0] spt;
    bit          typed;
    answer_t     ans;
  } row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic [3:0]  op = '0;
  logic [15:0] tool_number = '0;
  logic [7:0]  pocket_query = '0;
  logic        name_given = 1'b0;
  logic [15:0] spindle_tool = '0;
  logic        cfg_valid = 1'b0;
  logic [0:0]  cfg_index = '0;
  logic [7:0]  cfg_data = '0;
  logic        busy, cfg_ready, done, found;
  logic [2:0]  status;
  logic [15:0] tool_out;
  logic [7:0]  pocket_out, arriving_pocket;

  tool_pocket_table #(.TABLE_ENTRIES(ENTRIES)) DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .op(op),
    .tool_number(tool_number), .pocket_query(pocket_query),
    .name_given(name_given), .spindle_tool(spindle_tool),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .done(done), .status(status), .found(found),
    .tool_out(tool_out), .pocket_out(pocket_out),
    .arriving_pocket(arriving_pocket)
  );

  always #4 clk = ~clk;

  // shadow copy of the pocket table
  logic        e_valid [ENTRIES];
  logic [15:0] e_tool  [ENTRIES];
  logic [7:0]  e_pocket[ENTRIES];
  int          e_count;
  logic [15:0] spindle_cur;
  logic [7:0]  fetched;
  logic [7:0]  lim;
  logic        rdy;

  answer_t pending_answers[$];
  int      n_err = 0, n_answers = 0, n_requests = 0, n_full = 0, n_cfg = 0;
  longint  cyc = 0;
  int      idle_pct = 0;

  function automatic int slot_of(input logic [15:0] t);
    for (int i = 0; i < ENTRIES; i++)
      if (e_valid[i] && e_tool[i] == t) return i;
    return -1;
  endfunction

  function automatic bit pocket_taken(input int p);
    for (int i = 0; i < ENTRIES; i++)
      if (e_valid[i] && e_pocket[i] == p) return 1'b1;
    return 1'b0;
  endfunction

  function automatic int in_carousel();
    int n;
    n = 0;
    for (int i = 0; i < ENTRIES; i++)
      if (e_valid[i] && e_pocket[i] != 0) n++;
    return n;
  endfunction

  function automatic int lowest_free();
    int l;
    l = (lim != 0) ? int'(lim) : e_count + 1;
    if (l > 255) l = 255;
    for (int c = 1; c <= l; c++)
      if (!pocket_taken(c)) return c;
    return 0;
  endfunction

  function automatic bit add_entry(input logic [15:0] t, input logic [7:0] p);
    if (e_count >= ENTRIES) return 1'b0;
    for (int i = 0; i < ENTRIES; i++)
      if (!e_valid[i]) begin
        e_valid[i] = 1'b1;
        e_tool[i] = t;
        e_pocket[i] = p;
        e_count++;
        return 1'b1;
      end
    return 1'b0;
  endfunction

  function automatic logic [2:0] place_tool(input logic [15:0] t, output logic [7:0] p);
    int s, c;
    p = '0;
    if (!rdy) return tpt_pkg::ST_NOTLOAD;
    s = slot_of(t);
    if (s >= 0 && e_pocket[s] != 0) begin
      p = e_pocket[s];
      return tpt_pkg::ST_INPKT;
    end
    if (lim != 0 && in_carousel() >= int'(lim)) return tpt_pkg::ST_NOPKT;
    c = lowest_free();
    if (c == 0) return tpt_pkg::ST_NOPKT;
    if (s >= 0) e_pocket[s] = 8'(c);
    else if (!add_entry(t, 8'(c))) return tpt_pkg::ST_FULL;
    p = 8'(c);
    return tpt_pkg::ST_OK;
  endfunction

  function automatic logic [2:0] pull_tool(input logic [15:0] t, output logic [7:0] p);
    int s;
    p = '0;
    if (!rdy) return tpt_pkg::ST_NOTLOAD;
    s = slot_of(t);
    if (s < 0 || e_pocket[s] == 0) return tpt_pkg::ST_NOTFND;
    p = e_pocket[s];
    e_pocket[s] = '0;
    return tpt_pkg::ST_OK;
  endfunction

  function automatic answer_t predict_answer(input logic [3:0] o, input logic [15:0] t,
                                             input logic [7:0] pq, input logic nm,
                                             input logic [15:0] spt);
    answer_t a;
    int s;
    logic [7:0] p;
    logic [2:0] r;
    logic [15:0] prev;
    a = '0;
    p = '0;
    case (o)
      tpt_pkg::OP_REGISTER: begin
        if (!rdy) a.st = tpt_pkg::ST_NOTLOAD;
        else begin
          s = slot_of(t);
          if (s >= 0) begin
            a.fnd = 1'b1;
            a.pkt = e_pocket[s];
            a.st = nm ? tpt_pkg::ST_OK : tpt_pkg::ST_ALREADY;
          end else if (!add_entry(t, 8'd0)) a.st = tpt_pkg::ST_FULL;
        end
      end
      tpt_pkg::OP_ADD: begin
        a.st = place_tool(t, p);
        a.pkt = p;
      end
      tpt_pkg::OP_REMOVE: begin
        a.st = pull_tool(t, p);
        a.pkt = p;
      end
      tpt_pkg::OP_DELETE: begin
        if (!rdy) a.st = tpt_pkg::ST_NOTLOAD;
        else begin
          s = slot_of(t);
          if (s < 0) a.st = tpt_pkg::ST_NOTFND;
          else if (e_pocket[s] != 0) begin
            a.st = tpt_pkg::ST_INPKT;
            a.pkt = e_pocket[s];
          end else begin
            e_valid[s] = 1'b0;
            if (e_count > 0) e_count--;
          end
        end
      end
      tpt_pkg::OP_CHANGED: begin
        prev = spindle_cur;
        s = slot_of(t);
        a.fnd = (s >= 0);
        if (!rdy) a.st = tpt_pkg::ST_NOTLOAD;
        else if (s < 0 && !add_entry(t, 8'd0)) a.st = tpt_pkg::ST_FULL;
        if (lim != 0) begin
          s = slot_of(t);
          if (s >= 0 && e_pocket[s] != 0) a.inp = e_pocket[s];
          // capture the incoming pocket before freeing it
          if (a.inp != 0) void'(pull_tool(t, p));
          if (fetched != 0) begin
            r = place_tool(prev, p);
            if (r != tpt_pkg::ST_OK && a.st == tpt_pkg::ST_OK) a.st = r;
          end
          fetched = a.inp;
        end
        spindle_cur = t;
        a.tool = prev;
        a.pkt = fetched;
      end
      tpt_pkg::OP_FIND: begin
        s = slot_of(t);
        if (s >= 0) begin
          a.fnd = 1'b1;
          a.pkt = e_pocket[s];
        end else a.st = tpt_pkg::ST_NOTFND;
      end
      tpt_pkg::OP_FINDPKT: begin
        a.st = tpt_pkg::ST_NOTFND;
        if (pq != 0)
          for (int i = 0; i < ENTRIES; i++)
            if (e_valid[i] && e_pocket[i] == pq) begin
              a.st = tpt_pkg::ST_OK;
              a.fnd = 1'b1;
              a.tool = e_tool[i];
              a.pkt = pq;
              break;
            end
      end
      tpt_pkg::OP_SELECT: begin
        spindle_cur = t;
        a.pkt = fetched;
      end
      tpt_pkg::OP_SELNEXT: begin
        if (lim != 0) begin
          s = slot_of(t);
          a.fnd = (s >= 0);
          if (s >= 0 && e_pocket[s] != 0) a.inp = e_pocket[s];
          a.tool = spt;
          a.pkt = fetched;
        end
      end
      default: ;
    endcase
    if (a.st == tpt_pkg::ST_FULL) n_full++;
    return a;
  endfunction

  // results cannot be held off: check every strobe
  always @(posedge clk) begin
    answer_t got, want;
    cyc <= cyc + 1;
    if (cyc > MAX_CYC) begin
      $display("Timeout after %0d cycles", cyc);
      $display("Simulation FAILED");
      $finish;
    end
    if (!rst && done) begin
      got = '{status, found, tool_out, pocket_out, arriving_pocket};
      n_answers++;
      if (pending_answers.size() == 0) begin
        n_err++;
        $display("%0t: answer with none outstanding: %p", $time, got);
      end else begin
        want = pending_answers.pop_front();
        if (got !== want) begin
          n_err++;
          if (n_err <= 40)
            $display("%0t: mismatch expected %p, actual %p", $time, want, got);
        end
      end
    end
  end

  task automatic send_request(input logic [3:0] o, input logic [15:0] t,
                              input logic [7:0] pq, input logic nm,
                              input logic [15:0] spt, input bit typed,
                              input answer_t typed_ans);
    answer_t a;
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start        <= 1'b1;
    op           <= o;
    tool_number  <= t;
    pocket_query <= pq;
    name_given   <= nm;
    spindle_tool <= spt;
    do @(posedge clk); while (busy);
    a = predict_answer(o, t, pq, nm, spt);
    pending_answers.push_back(typed ? typed_ans : a);
    n_requests++;
  endtask

  task automatic write_reg(input logic [0:0] idx, input logic [7:0] val);
    start <= 1'b0;
    @(posedge clk);
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == tpt_pkg::CFG_LIMIT) lim = val;
    else rdy = val[0];
    n_cfg++;
  endtask

  function automatic row_t req(input logic [3:0] o, input logic [15:0] t,
                               input logic [7:0] pq, input logic nm,
                               input logic [15:0] spt);
    row_t r;
    r = '{default: '0};
    r.op = o; r.tool = t; r.pq = pq; r.nm = nm; r.spt = spt;
    return r;
  endfunction

  function automatic row_t req_exp(input logic [3:0] o, input logic [15:0] t,
                                   input logic [7:0] pq, input logic nm,
                                   input answer_t a);
    row_t r;
    r = req(o, t, pq, nm, 16'h0);
    r.typed = 1'b1;
    r.ans = a;
    return r;
  endfunction

  function automatic row_t reg_row(input logic [0:0] idx, input logic [7:0] val);
    row_t r;
    r = '{default: '0};
    r.is_cfg = 1'b1; r.idx = idx; r.val = val;
    return r;
  endfunction

  initial begin
    row_t plan[$];
    logic [7:0] limits[5];
    logic       readys[5];
    int         profile[3];
    logic [3:0] o;
    logic [15:0] t;
    logic [7:0] pq;
    int w;

    limits  = '{8'd0, 8'd3, 8'd255, 8'd1, 8'd16};
    readys  = '{1'b1, 1'b1, 1'b1, 1'b0, 1'b1};
    profile = '{18, 69, 0};

    for (int i = 0; i < ENTRIES; i++) begin
      e_valid[i] = 1'b0; e_tool[i] = '0; e_pocket[i] = '0;
    end
    e_count = 0; spindle_cur = '0; fetched = '0; lim = '0; rdy = 1'b0;

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // unloaded table straight after reset
    plan.push_back(req_exp(tpt_pkg::OP_REGISTER, 16'd5, 8'd0, 1'b0,
                           '{tpt_pkg::ST_NOTLOAD, 1'b0, 16'h0, 8'd0, 8'd0}));
    plan.push_back(req_exp(tpt_pkg::OP_ADD, 16'd5, 8'd0, 1'b0,
                           '{tpt_pkg::ST_NOTLOAD, 1'b0, 16'h0, 8'd0, 8'd0}));
    plan.push_back(req_exp(tpt_pkg::OP_REMOVE, 16'd5, 8'd0, 1'b0,
                           '{tpt_pkg::ST_NOTLOAD, 1'b0, 16'h0, 8'd0, 8'd0}));
    plan.push_back(req_exp(tpt_pkg::OP_DELETE, 16'd5, 8'd0, 1'b0,
                           '{tpt_pkg::ST_NOTLOAD, 1'b0, 16'h0, 8'd0, 8'd0}));
    plan.push_back(req_exp(tpt_pkg::OP_FIND, 16'd5, 8'd0, 1'b0,
                           '{tpt_pkg::ST_NOTFND, 1'b0, 16'h0, 8'd0, 8'd0}));
    plan.push_back(req_exp(tpt_pkg::OP_FINDPKT, 16'd0, 8'd0, 1'b0,
                           '{tpt_pkg::ST_NOTFND, 1'b0, 16'h0, 8'd0, 8'd0}));
    plan.push_back(req_exp(tpt_pkg::OP_SELNEXT, 16'd5, 8'd0, 1'b0,
                           '{tpt_pkg::ST_OK, 1'b0, 16'h0, 8'd0, 8'd0}));
    plan.push_back(req_exp(tpt_pkg::OP_SELECT, 16'hFFFF, 8'd0, 1'b0,
                           '{tpt_pkg::ST_OK, 1'b0, 16'h0, 8'd0, 8'd0}));
    plan.push_back(req_exp(OP_UNUSED, 16'hFFFF, 8'hFF, 1'b1,
                           '{tpt_pkg::ST_OK, 1'b0, 16'h0, 8'd0, 8'd0}));
    plan.push_back(reg_row(tpt_pkg::CFG_READY, 8'd1));
    plan.push_back(req_exp(tpt_pkg::OP_REGISTER, 16'd0, 8'd0, 1'b0,
                           '{tpt_pkg::ST_OK, 1'b0, 16'h0, 8'd0, 8'd0}));
    plan.push_back(req_exp(tpt_pkg::OP_REGISTER, 16'd0, 8'd0, 1'b0,
                           '{tpt_pkg::ST_ALREADY, 1'b1, 16'h0, 8'd0, 8'd0}));
    plan.push_back(req_exp(tpt_pkg::OP_REGISTER, 16'd0, 8'd0, 1'b1,
                           '{tpt_pkg::ST_OK, 1'b1, 16'h0, 8'd0, 8'd0}));
    plan.push_back(req_exp(tpt_pkg::OP_ADD, 16'hFFFF, 8'd0, 1'b0,
                           '{tpt_pkg::ST_OK, 1'b0, 16'h0, 8'd1, 8'd0}));
    plan.push_back(req_exp(tpt_pkg::OP_ADD, 16'hFFFF, 8'd0, 1'b0,
                           '{tpt_pkg::ST_INPKT, 1'b0, 16'h0, 8'd1, 8'd0}));
    plan.push_back(req(tpt_pkg::OP_ADD, 16'd0, 8'd0, 1'b0, 16'h0));
    plan.push_back(req_exp(tpt_pkg::OP_FINDPKT, 16'd0, 8'd1, 1'b0,
                           '{tpt_pkg::ST_OK, 1'b1, 16'hFFFF, 8'd1, 8'd0}));
    plan.push_back(req_exp(tpt_pkg::OP_FINDPKT, 16'd0, 8'hFF, 1'b0,
                           '{tpt_pkg::ST_NOTFND, 1'b0, 16'h0, 8'd0, 8'd0}));
    plan.push_back(req_exp(tpt_pkg::OP_DELETE, 16'hFFFF, 8'd0, 1'b0,
                           '{tpt_pkg::ST_INPKT, 1'b0, 16'h0, 8'd1, 8'd0}));
    plan.push_back(req_exp(tpt_pkg::OP_REMOVE, 16'hFFFF, 8'd0, 1'b0,
                           '{tpt_pkg::ST_OK, 1'b0, 16'h0, 8'd1, 8'd0}));
    plan.push_back(req_exp(tpt_pkg::OP_DELETE, 16'hFFFF, 8'd0, 1'b0,
                           '{tpt_pkg::ST_OK, 1'b0, 16'h0, 8'd0, 8'd0}));
    plan.push_back(req_exp(tpt_pkg::OP_REMOVE, 16'h1234, 8'd0, 1'b0,
                           '{tpt_pkg::ST_NOTFND, 1'b0, 16'h0, 8'd0, 8'd0}));
    plan.push_back(reg_row(tpt_pkg::CFG_LIMIT, 8'd255));
    plan.push_back(req(tpt_pkg::OP_CHANGED, 16'd0, 8'd0, 1'b0, 16'h0));
    plan.push_back(req(tpt_pkg::OP_SELNEXT, 16'd0, 8'd0, 1'b0, 16'hFFFF));
    plan.push_back(req(tpt_pkg::OP_CHANGED, 16'hAAAA, 8'd0, 1'b0, 16'h0));
    plan.push_back(reg_row(tpt_pkg::CFG_LIMIT, 8'd1));
    plan.push_back(req(tpt_pkg::OP_ADD, 16'h5555, 8'd0, 1'b0, 16'h0));
    plan.push_back(req(tpt_pkg::OP_CHANGED, 16'h5555, 8'd0, 1'b0, 16'h0));

    idle_pct = 18;
    foreach (plan[i]) begin
      if (plan[i].is_cfg) write_reg(plan[i].idx, plan[i].val);
      else send_request(plan[i].op, plan[i].tool, plan[i].pq, plan[i].nm,
                        plan[i].spt, plan[i].typed, plan[i].ans);
    end

    foreach (profile[pi]) begin
      idle_pct = profile[pi];
      foreach (limits[si]) begin
        write_reg(tpt_pkg::CFG_LIMIT, limits[si]);
        write_reg(tpt_pkg::CFG_READY, {7'd0, readys[si]});
        for (int k = 0; k < 68; k++) begin
          // bias towards registrations and adds so the table fills up
          w = $urandom_range(99);
          if (w < 25)      o = tpt_pkg::OP_REGISTER;
          else if (w < 40) o = tpt_pkg::OP_ADD;
          else if (w < 50) o = tpt_pkg::OP_REMOVE;
          else if (w < 58) o = tpt_pkg::OP_DELETE;
          else if (w < 70) o = tpt_pkg::OP_CHANGED;
          else if (w < 77) o = tpt_pkg::OP_FIND;
          else if (w < 84) o = tpt_pkg::OP_FINDPKT;
          else if (w < 89) o = tpt_pkg::OP_SELECT;
          else if (w < 97) o = tpt_pkg::OP_SELNEXT;
          else             o = 4'($urandom_range(9, 15));
          t  = ($urandom_range(99) < 88) ? 16'($urandom_range(0, 90)) : 16'($urandom);
          pq = ($urandom_range(99) < 75) ? 8'($urandom_range(0, 24)) : 8'($urandom);
          send_request(o, t, pq, 1'($urandom), 16'($urandom), 1'b0, '0);
        end
      end
    end
    start <= 1'b0;

    while (pending_answers.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);

    $display("Ran %0d requests, %0d answers, %0d register writes, %0d full-table answers",
             n_requests, n_answers, n_cfg, n_full);
    $display("Pocket limits 0, 1, 3, 16 and 255, table loaded and unloaded, %0d errors",
             n_err);
    if (n_err == 0 && pending_answers.size() == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end
endmodule

### tool_pocket_table.f
+incdir+rtl
rtl/tpt_pkg.sv
rtl/tpt_ram.sv
rtl/tool_pocket_table.sv
sim/tb_tool_pocket_table.sv
